// File: sv/mfu_page_replacement_core_defines.svh
// assertion macros for the mfu page replacement checker
// used by mfu_page_replacement_checker.sv, no other dependencies
`ifndef MFU_PAGE_REPLACEMENT_CORE_DEFINES_SVH
`define MFU_PAGE_REPLACEMENT_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MFU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mfu page replacement: same-cycle check failed");

// next-cycle implication, disabled during reset
`define MFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mfu page replacement: next-cycle check failed");

`endif

// File: sv/mfu_pkg.sv
// shared constants for the mfu page replacement block
// no dependencies; used by the channel interfaces, the core and the checker
`timescale 1ns / 1ps

package mfu_pkg;

    localparam int CFG_BITS      = 4;   // frames_in_use write word width
    localparam int PAGE_IO_BITS  = 16;  // page and evicted_page word width
    localparam int IDX_IO_BITS   = 3;   // frame_index word width
    localparam int TOTAL_BITS    = 32;  // hit and fault totals
    localparam int TIME_BITS     = 32;  // access time and load time

endpackage

// File: sv/mfu_if.sv
// valid/ready channel interfaces: page requests, results, configuration
// depends on mfu_pkg
`timescale 1ns / 1ps

interface mfu_req_if
    import mfu_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [PAGE_IO_BITS-1:0] page;

    modport source (output valid, output page, input ready);
    modport sink   (input valid, input page, output ready);
endinterface

interface mfu_rsp_if
    import mfu_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic [IDX_IO_BITS-1:0]  frame_index;
    logic                    evicted_valid;
    logic [PAGE_IO_BITS-1:0] evicted_page;
    logic [TOTAL_BITS-1:0]   hit_total;
    logic [TOTAL_BITS-1:0]   fault_total;

    modport source (output valid, output hit, output frame_index, output evicted_valid,
                    output evicted_page, output hit_total, output fault_total,
                    input ready);
    modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                    input evicted_page, input hit_total, input fault_total,
                    output ready);
endinterface

interface mfu_cfg_if
    import mfu_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/mfu_frame_ram.sv
// frame table ram: one write port, one read port, registered read data
// no package dependencies
`timescale 1ns / 1ps

module mfu_frame_ram #(
    parameter int DEPTH     = 8,
    parameter int ADDR_BITS = 3,
    parameter int WIDTH     = 64
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/mfu_page_replacement_core.sv
// most-frequently-used page replacement core, top level
// depends on mfu_pkg, mfu_if (channel interfaces) and mfu_frame_ram
`timescale 1ns / 1ps

// usage
//   req: one page reference per word (valid/ready), low PAGE_BITS bits used
//   rsp: one result word per reference: hit, frame_index, evicted_valid,
//        evicted_page, hit_total, fault_total
//   cfg: frames_in_use write channel, always ready; 0 acts as 1 and values
//        above FRAMES act as FRAMES; write only while no reference is in flight
// timing
//   the frame table sits in a single-port-read ram; every reference scans the
//   n frames in use, one ram read per cycle, then writes back one entry
//   the result is registered at write-back, and a new reference is taken
//   only after the previous one has written back and the core is idle again
// reset
//   all frames empty, totals and access time zero, frames_in_use = FRAMES
// stall
//   the result waits in an output register; the next reference is accepted
//   and scanned meanwhile, and its write-back holds until the register frees

module mfu_page_replacement_core
    import mfu_pkg::*;
#(
    parameter int FRAMES     = 8,
    parameter int PAGE_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    mfu_req_if.sink   req,
    mfu_rsp_if.source rsp,
    mfu_cfg_if.sink   cfg
);

    localparam int FI = (FRAMES > 1) ? $clog2(FRAMES) : 1;   // frame index bits
    localparam int CW = $clog2(FRAMES + 1);                  // frame count bits
    localparam int WW = PAGE_BITS + COUNT_BITS + TIME_BITS;  // ram word bits

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    // control state
    logic [1:0]            state_reg, state_next;
    logic [CW-1:0]         frames_cfg_reg;
    logic [FRAMES-1:0]     valid_reg;
    logic [TIME_BITS-1:0]  access_time_reg;
    logic [TOTAL_BITS-1:0] hits_reg, faults_reg;
    logic                  out_valid_reg;

    // per-reference scan state
    logic [CW-1:0]         n_reg;
    logic [CW-1:0]         rd_cnt_reg;
    logic                  proc_valid_reg;
    logic [FI-1:0]         proc_idx_reg;
    logic [PAGE_BITS-1:0]  pg_reg;
    logic                  found_reg, empty_reg;
    logic [FI-1:0]         hit_idx_reg, empty_idx_reg, best_idx_reg;
    logic [COUNT_BITS-1:0] hit_cnt_reg, best_cnt_reg;
    logic [TIME_BITS-1:0]  hit_load_reg, best_age_reg;
    logic [PAGE_BITS-1:0]  best_page_reg;

    // result payload
    logic                    o_hit_reg;
    logic [IDX_IO_BITS-1:0]  o_idx_reg;
    logic                    o_evv_reg;
    logic [PAGE_IO_BITS-1:0] o_evp_reg;
    logic [TOTAL_BITS-1:0]   o_hits_reg, o_faults_reg;

    logic                  req_fire, rsp_fire, wr_fire;
    logic                  rd_en;
    logic [WW-1:0]         rd_data, wr_data;
    logic [PAGE_BITS-1:0]  rd_page;
    logic [COUNT_BITS-1:0] rd_cnt_val;
    logic [TIME_BITS-1:0]  rd_load, rd_age;
    logic                  rd_valid, better;
    logic [FI-1:0]         wr_slot;
    logic [COUNT_BITS-1:0] hit_cnt_inc;
    logic [CW-1:0]         cfg_eff;

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign req_fire  = req.valid && req.ready;
    assign rsp_fire  = rsp.valid && rsp.ready;
    assign wr_fire   = (state_reg == ST_WRITE) && (!out_valid_reg || rsp.ready);
    assign rd_en     = (state_reg == ST_SCAN) && (rd_cnt_reg < n_reg);

    // clamp of the register write into 1..FRAMES
    always_comb
    begin
        if (cfg.data == '0)
        begin
            cfg_eff = CW'(1);
        end
        else if (32'(cfg.data) > 32'(FRAMES))
        begin
            cfg_eff = CW'(FRAMES);
        end
        else
        begin
            cfg_eff = CW'(cfg.data);
        end
    end

    // ram word: page, use count, load time
    assign rd_page    = rd_data[WW-1 -: PAGE_BITS];
    assign rd_cnt_val = rd_data[TIME_BITS +: COUNT_BITS];
    assign rd_load    = rd_data[TIME_BITS-1:0];
    assign rd_age     = access_time_reg - rd_load;
    assign rd_valid   = valid_reg[proc_idx_reg];
    assign better     = (rd_cnt_val > best_cnt_reg) ||
                        ((rd_cnt_val == best_cnt_reg) && (rd_age > best_age_reg));

    // saturating use count on a hit
    assign hit_cnt_inc = (&hit_cnt_reg) ? hit_cnt_reg : hit_cnt_reg + COUNT_BITS'(1);

    // write-back entry
    always_comb
    begin
        if (found_reg)
        begin
            wr_slot = hit_idx_reg;
            wr_data = {pg_reg, hit_cnt_inc, hit_load_reg};
        end
        else if (empty_reg)
        begin
            wr_slot = empty_idx_reg;
            wr_data = {pg_reg, COUNT_BITS'(1), access_time_reg};
        end
        else
        begin
            wr_slot = best_idx_reg;
            wr_data = {pg_reg, COUNT_BITS'(1), access_time_reg};
        end
    end

    mfu_frame_ram #(
        .DEPTH     (FRAMES),
        .ADDR_BITS (FI),
        .WIDTH     (WW)
    ) u_frame_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_cnt_reg[FI-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_fire),
        .wr_addr (wr_slot),
        .wr_data (wr_data)
    );

    // sequencer: idle, scan the frames in use, write back
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!rd_en && !proc_valid_reg)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (wr_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            frames_cfg_reg  <= CW'(FRAMES);
            valid_reg       <= '0;
            access_time_reg <= '0;
            hits_reg        <= '0;
            faults_reg      <= '0;
            out_valid_reg   <= 1'b0;
            proc_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            proc_valid_reg <= rd_en;
            if (cfg.valid && cfg.ready)
            begin
                frames_cfg_reg <= cfg_eff;
            end
            if (wr_fire)
            begin
                access_time_reg <= access_time_reg + TIME_BITS'(1);
                out_valid_reg   <= 1'b1;
                if (found_reg)
                begin
                    hits_reg <= hits_reg + TOTAL_BITS'(1);
                end
                else
                begin
                    faults_reg         <= faults_reg + TOTAL_BITS'(1);
                    valid_reg[wr_slot] <= 1'b1;
                end
            end
            else if (rsp_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // scan datapath: first match, first empty frame, eviction candidate
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            pg_reg     <= PAGE_BITS'(req.page);
            n_reg      <= frames_cfg_reg;
            rd_cnt_reg <= '0;
            found_reg  <= 1'b0;
            empty_reg  <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_cnt_reg <= rd_cnt_reg + CW'(1);
            end
            proc_idx_reg <= rd_cnt_reg[FI-1:0];
            if (proc_valid_reg)
            begin
                if (rd_valid && (rd_page == pg_reg) && !found_reg)
                begin
                    found_reg    <= 1'b1;
                    hit_idx_reg  <= proc_idx_reg;
                    hit_cnt_reg  <= rd_cnt_val;
                    hit_load_reg <= rd_load;
                end
                if (!rd_valid && !empty_reg)
                begin
                    empty_reg     <= 1'b1;
                    empty_idx_reg <= proc_idx_reg;
                end
                // frame zero seeds the candidate, later frames must beat it
                if ((proc_idx_reg == '0) || better)
                begin
                    best_idx_reg  <= proc_idx_reg;
                    best_cnt_reg  <= rd_cnt_val;
                    best_age_reg  <= rd_age;
                    best_page_reg <= rd_page;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            o_hit_reg    <= found_reg;
            o_idx_reg    <= IDX_IO_BITS'(wr_slot);
            o_evv_reg    <= !found_reg && !empty_reg;
            o_evp_reg    <= (!found_reg && !empty_reg) ? PAGE_IO_BITS'(best_page_reg) : '0;
            o_hits_reg   <= found_reg ? hits_reg + TOTAL_BITS'(1) : hits_reg;
            o_faults_reg <= found_reg ? faults_reg : faults_reg + TOTAL_BITS'(1);
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = o_hit_reg;
    assign rsp.frame_index   = o_idx_reg;
    assign rsp.evicted_valid = o_evv_reg;
    assign rsp.evicted_page  = o_evp_reg;
    assign rsp.hit_total     = o_hits_reg;
    assign rsp.fault_total   = o_faults_reg;

endmodule

// File: sv/mfu_page_replacement_checker.sv
// port-level checks for mfu_page_replacement_core, bound to the top level
// depends on mfu_pkg and mfu_page_replacement_core_defines.svh
`timescale 1ns / 1ps
`include "mfu_page_replacement_core_defines.svh"

module mfu_page_replacement_checker
    import mfu_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    req_valid,
    input logic                    req_ready,
    input logic                    rsp_valid,
    input logic                    rsp_ready,
    input logic                    rsp_hit,
    input logic [IDX_IO_BITS-1:0]  rsp_frame_index,
    input logic                    rsp_evicted_valid,
    input logic [PAGE_IO_BITS-1:0] rsp_evicted_page,
    input logic [TOTAL_BITS-1:0]   rsp_hit_total,
    input logic [TOTAL_BITS-1:0]   rsp_fault_total
);

    // hits plus faults seen in the last delivered word
    logic [TOTAL_BITS-1:0] sum_reg;
    logic [TOTAL_BITS-1:0] sum_now;

    assign sum_now = rsp_hit_total + rsp_fault_total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            sum_reg <= sum_now;
        end
    end

    // every result word accounts for exactly one more reference
    `MFU_ASSERT_NOW(a_total_step, clk, rst_n, rsp_valid, sum_now == sum_reg + TOTAL_BITS'(1))

    // a hit never evicts, and a word without an eviction shows a zero page
    `MFU_ASSERT_NOW(a_hit_no_evict, clk, rst_n, rsp_valid && (rsp_hit || !rsp_evicted_valid), !rsp_evicted_valid && (rsp_evicted_page == '0))

    // one reference in flight at a time
    `MFU_ASSERT_NEXT(a_req_busy, clk, rst_n, req_valid && req_ready, !req_ready)

    // a stalled result word stays valid, with its frame index and totals held
    `MFU_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_frame_index) && $stable(sum_now))

endmodule

bind mfu_page_replacement_core mfu_page_replacement_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_hit           (rsp.hit),
    .rsp_frame_index   (rsp.frame_index),
    .rsp_evicted_valid (rsp.evicted_valid),
    .rsp_evicted_page  (rsp.evicted_page),
    .rsp_hit_total     (rsp.hit_total),
    .rsp_fault_total   (rsp.fault_total)
);
